@@ sv/qts_pkg.sv @@
`default_nettype none
package qts_pkg;

  // Command codes of an input item
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes of a result item
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Value returned by a dequeue on an empty queue
  localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } qts_in_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
  } qts_out_t;

  // Which result the output register is loaded with
  typedef enum logic [1:0] {
    RES_ENQ_OK,
    RES_FULL,
    RES_EMPTY,
    RES_POP
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     push;     // write input value onto input stack
    logic     move_rd;  // pop input stack top toward output stack
    logic     pop_rd;   // read output stack top, decrement count
    logic     load;     // load result into output register
    res_sel_e res_sel;
  } qts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_zero;
    logic in_one;
    logic in_full;
    logic out_zero;
  } qts_sts_t;

endpackage
`default_nettype wire

@@ sv/qts_dp.sv @@
`default_nettype none
module qts_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire qts_pkg::qts_cmd_t cmd_i,
  input  wire logic signed [31:0] value_i,
  output qts_pkg::qts_sts_t     sts_o,
  output qts_pkg::qts_out_t     res_o
);
  import qts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] in_mem  [DEPTH];
  logic signed [31:0] out_mem [DEPTH];

  logic [CW-1:0]      in_cnt_q, in_cnt_d;
  logic [CW-1:0]      out_cnt_q, out_cnt_d;
  logic [CW-1:0]      in_cnt_m1, out_cnt_m1;
  logic               mv_pend_q;
  logic signed [31:0] in_rdata_q;
  logic signed [31:0] out_rdata_q;
  qts_out_t           res_q, res_d;

  assign in_cnt_m1  = in_cnt_q - CW'(1);
  assign out_cnt_m1 = out_cnt_q - CW'(1);

  // Status toward the controller
  assign sts_o.in_zero  = (in_cnt_q == '0);
  assign sts_o.in_one   = (in_cnt_q == CW'(1));
  assign sts_o.in_full  = (in_cnt_q == CW'(DEPTH));
  assign sts_o.out_zero = (out_cnt_q == '0);

  // Count updates; a moved entry lands in the cycle after its read
  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    if (cmd_i.push) begin
      in_cnt_d = in_cnt_q + CW'(1);
    end else if (cmd_i.move_rd) begin
      in_cnt_d = in_cnt_m1;
    end
    if (mv_pend_q) begin
      out_cnt_d = out_cnt_q + CW'(1);
    end else if (cmd_i.pop_rd) begin
      out_cnt_d = out_cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      mv_pend_q <= 1'b0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      mv_pend_q <= cmd_i.move_rd;
    end
  end

  // Input stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      in_mem[in_cnt_q[AW-1:0]] <= value_i;
    end
    if (cmd_i.move_rd) begin
      in_rdata_q <= in_mem[in_cnt_m1[AW-1:0]];
    end
  end

  // Output stack memory
  always_ff @(posedge clk_i) begin
    if (mv_pend_q) begin
      out_mem[out_cnt_q[AW-1:0]] <= in_rdata_q;
    end
    if (cmd_i.pop_rd) begin
      out_rdata_q <= out_mem[out_cnt_m1[AW-1:0]];
    end
  end

  // Result select
  always_comb begin
    unique case (cmd_i.res_sel)
      RES_ENQ_OK: res_d = '{data_out: '0, status: ST_OK};
      RES_FULL:   res_d = '{data_out: '0, status: ST_FULL};
      RES_EMPTY:  res_d = '{data_out: EMPTY_DATA, status: ST_EMPTY};
      RES_POP:    res_d = '{data_out: out_rdata_q, status: ST_OK};
      default:    res_d = '{data_out: '0, status: ST_OK};
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !sts_o.in_full)
    else $error("push onto full input stack");

  a_move_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_rd |-> !sts_o.in_zero)
    else $error("move from empty input stack");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_rd |-> (!sts_o.out_zero && !mv_pend_q))
    else $error("pop from empty output stack or during move");

  a_move_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_pend_q |-> (out_cnt_q != CW'(DEPTH)))
    else $error("moved entry overflows output stack");

endmodule
`default_nettype wire

@@ sv/qts_ctrl.sv @@
`default_nettype none
module qts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_command_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire qts_pkg::qts_sts_t sts_i,
  output qts_pkg::qts_cmd_t      cmd_o
);
  import qts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_MOVE_LAST,
    S_POP,
    S_RESP
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     out_valid_q, out_valid_d;
  logic     slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    res_sel_d     = res_sel_q;
    cmd_o.push    = 1'b0;
    cmd_o.move_rd = 1'b0;
    cmd_o.pop_rd  = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.res_sel = res_sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RESP;
          if (in_command_i == CMD_ENQ) begin
            if (!sts_i.in_full) begin
              cmd_o.push = 1'b1;
              res_sel_d  = RES_ENQ_OK;
            end else begin
              res_sel_d = RES_FULL;
            end
          end else if (!sts_i.out_zero) begin
            cmd_o.pop_rd = 1'b1;
            res_sel_d    = RES_POP;
          end else if (sts_i.in_zero) begin
            res_sel_d = RES_EMPTY;
          end else begin
            state_d = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        cmd_o.move_rd = 1'b1;
        if (sts_i.in_one) begin
          state_d = S_MOVE_LAST;
        end
      end
      // last moved entry is written this cycle
      S_MOVE_LAST: state_d = S_POP;
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        res_sel_d    = RES_POP;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared once the transfer completes
  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_sel_q   <= RES_ENQ_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> slot_free)
    else $error("result loaded over a pending transfer");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("loaded result not presented");

  a_pop_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_rd |=> (state_q == S_RESP && res_sel_q == RES_POP))
    else $error("pop not followed by its response");

endmodule
`default_nettype wire

@@ sv/queue_from_two_stacks.sv @@
`default_nettype none
// First-in first-out queue of signed 32-bit values built from two stacks of
// DEPTH entries each. Each input transfer is an enqueue or a dequeue and
// gives exactly one result transfer (data_out, status).
// Input channel: in_valid_i / in_stall_o with payload in_i. A transfer
// happens when valid is high and stall is low. One item is worked on at a
// time; in_stall_o is high from the cycle after acceptance until the result
// sits in the output register.
// Output channel: out_valid_o / out_stall_i with payload out_o, driven from
// a register. While the receiver stalls, the result holds and the next item
// can still be accepted; its result waits until the register frees up.
// Steps: an enqueue, a refused enqueue, an empty dequeue or a dequeue from a
// non-empty output stack goes from acceptance to the response state and loads
// its result there once the output register is free. A dequeue that finds the
// output stack empty first moves all n input-stack entries, one per cycle
// through the single read port of the input stack memory, then pops the
// output stack top and loads it as the result once the register is free.
// Reset clears both stack counts, so the queue starts empty; stack memory
// contents are not cleared and need no clearing pass.
module queue_from_two_stacks #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire qts_pkg::qts_in_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output qts_pkg::qts_out_t     out_o
);
  import qts_pkg::*;

  qts_cmd_t cmd;
  qts_sts_t sts;

  qts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qts_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .value_i(in_i.value),
    .sts_o  (sts),
    .res_o  (out_o)
  );

endmodule
`default_nettype wire
